FILE: hw/rtl/pfs_pkg.sv
package pfs_pkg;

   localparam int OpWidth      = 4;
   localparam int TagWidth     = 32;
   localparam int ValueWidth   = 64;
   localparam int ByteWidth    = 8;
   localparam int ReqDataWidth = 104;
   localparam int CountWidth   = 4;

   // Command queue between the classifier and the byte emitter.
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   // Field kinds carried on the request kind port.
   localparam logic [OpWidth-1:0] OpBool     = 4'd0;
   localparam logic [OpWidth-1:0] OpU32      = 4'd1;
   localparam logic [OpWidth-1:0] OpS32      = 4'd2;
   localparam logic [OpWidth-1:0] OpFixed32  = 4'd3;
   localparam logic [OpWidth-1:0] OpU64      = 4'd4;
   localparam logic [OpWidth-1:0] OpS64      = 4'd5;
   localparam logic [OpWidth-1:0] OpFixed64  = 4'd6;
   localparam logic [OpWidth-1:0] OpOptU32   = 4'd7;
   localparam logic [OpWidth-1:0] OpLenHdr   = 4'd8;

   localparam logic [CountWidth-1:0] Fixed32Bytes = 4'd4;
   localparam logic [CountWidth-1:0] Fixed64Bytes = 4'd8;

   typedef enum logic [1:0] {
      MODE_VARINT,
      MODE_FIXED32,
      MODE_FIXED64
   } mode_type;

   typedef struct packed {
      logic                  send_tag;
      mode_type              mode;
      logic [TagWidth-1:0]   tag;
      logic [ValueWidth-1:0] enc;
   } field_cmd_type;

endpackage

FILE: hw/rtl/protobuf_field_serializer_top.sv
// Protobuf scalar field serializer. Each request is one scalar field: its kind
// on req_tuser and its key, 64 value bits and two flags on req_tdata. The block
// sends the key as a varint and then the value's wire bytes (varint, zigzag
// varint, bool, little-endian fixed32 or fixed64, or a varint length header),
// one byte per response, with rsp_tlast high on the field's final byte. A field
// whose value is zero is dropped unless marked present; an optional u32 goes out
// only when present; a packed element omits the key and always goes out; unused
// kinds produce nothing. The single byte emitter in the back end loads each
// field's command and then shifts out its bytes one by one; rsp_tready low
// stalls it. The classifier stage and a two-entry command queue let new
// requests be taken while the emitter is still busy, so dropped fields cost
// no emitter time.
module protobuf_field_serializer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] tag, [95:32] value, [96] present, [97] packed_req, [103:98] zero.
   input  logic [103:0] req_tdata,
   // [3:0] op.
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] out_byte.
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);
   import pfs_pkg::*;

   logic          front_valid;
   logic          front_ready;
   field_cmd_type front_cmd;
   logic          back_valid;
   logic          back_ready;
   field_cmd_type back_cmd;

   // Classifies each request and computes its encoded value.
   pfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // Decouples the classifier from the byte emitter.
   pfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   // Shifts out the key and value bytes through a registered output.
   pfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/pfs_front.sv
module pfs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pfs_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic [pfs_pkg::OpWidth-1:0]   req_tuser,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output pfs_pkg::field_cmd_type        cmd
);
   import pfs_pkg::*;

   logic                  cmd_valid_ff, cmd_valid_in;
   field_cmd_type         cmd_ff, cmd_in;
   logic [TagWidth-1:0]   tag;
   logic [ValueWidth-1:0] value;
   logic [31:0]           lo32;
   logic                  present;
   logic                  packed_req;
   logic                  known;
   logic                  nonzero;
   logic                  emit;

   assign tag        = req_tdata[31:0];
   assign value      = req_tdata[95:32];
   assign present    = req_tdata[96];
   assign packed_req = req_tdata[97];
   assign lo32       = value[31:0];

   // Work out the wire encoding of the value and whether the field goes out at all.
   always_comb begin
      known           = 1'b1;
      nonzero         = 1'b0;
      cmd_in.send_tag = !packed_req;
      cmd_in.mode     = MODE_VARINT;
      cmd_in.tag      = tag;
      cmd_in.enc      = '0;
      unique case (req_tuser) inside
         OpBool: begin
            nonzero    = |value;
            cmd_in.enc = {{(ValueWidth-1){1'b0}}, nonzero};
         end
         OpU32, OpLenHdr: begin
            nonzero    = |lo32;
            cmd_in.enc = {32'd0, lo32};
         end
         OpOptU32: begin
            // An optional field goes out only when it is set, whatever its value.
            cmd_in.enc = {32'd0, lo32};
         end
         OpFixed32: begin
            nonzero     = |lo32;
            cmd_in.enc  = {32'd0, lo32};
            cmd_in.mode = MODE_FIXED32;
         end
         OpS32: begin
            nonzero    = |lo32;
            cmd_in.enc = {32'd0, {lo32[30:0], 1'b0} ^ {32{lo32[31]}}};
         end
         OpU64: begin
            nonzero    = |value;
            cmd_in.enc = value;
         end
         OpFixed64: begin
            nonzero     = |value;
            cmd_in.enc  = value;
            cmd_in.mode = MODE_FIXED64;
         end
         OpS64: begin
            nonzero    = |value;
            cmd_in.enc = {value[62:0], 1'b0} ^ {ValueWidth{value[63]}};
         end
         default: begin
            known = 1'b0;
         end
      endcase
      emit = known && (nonzero || present || packed_req);
   end

   assign req_tready   = !cmd_valid_ff || cmd_ready;
   assign cmd_valid_in = req_tready ? (req_tvalid && emit) : cmd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

FILE: hw/rtl/pfs_queue.sv
module pfs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  pfs_pkg::field_cmd_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output pfs_pkg::field_cmd_type pop_data
);
   import pfs_pkg::*;

   field_cmd_type            entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   count_ff, count_in;
   logic                     push_fire;
   logic                     pop_fire;

   assign push_ready = count_ff != (QueuePtrWidth+1)'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QueuePtrWidth+1)'(QueueDepth))
      else $error("command queue holds more entries than it has");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue lost a pushed entry");

endmodule

FILE: hw/rtl/pfs_back.sv
module pfs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  pfs_pkg::field_cmd_type        cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pfs_pkg::ByteWidth-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import pfs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_KEY   = 3'b010,
      ST_VALUE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [TagWidth-1:0]   shift_tag_ff, shift_tag_in;
   logic [ValueWidth-1:0] shift_value_ff, shift_value_in;
   logic [CountWidth-1:0] bytes_left_ff, bytes_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  tag_more;
   logic                  value_more;

   // The output register can take a new byte when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign tag_more   = |shift_tag_ff[TagWidth-1:7];
   assign value_more = |shift_value_ff[ValueWidth-1:7];
   assign cmd_ready  = out_free && (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      shift_tag_in   = shift_tag_ff;
      shift_value_in = shift_value_ff;
      bytes_left_in  = bytes_left_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  mode_in        = cmd.mode;
                  shift_tag_in   = cmd.tag;
                  shift_value_in = cmd.enc;
                  case (cmd.mode)
                     MODE_FIXED32: bytes_left_in = Fixed32Bytes;
                     MODE_FIXED64: bytes_left_in = Fixed64Bytes;
                     default:      bytes_left_in = '0;
                  endcase
                  state_in = cmd.send_tag ? ST_KEY : ST_VALUE;
               end
            end
            ST_KEY: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (tag_more) begin
                  rsp_data_in  = {1'b1, shift_tag_ff[6:0]};
                  shift_tag_in = shift_tag_ff >> 7;
               end else begin
                  rsp_data_in  = shift_tag_ff[7:0];
                  shift_tag_in = '0;
                  state_in     = ST_VALUE;
               end
            end
            ST_VALUE: begin
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_VARINT) begin
                  rsp_data_in    = value_more ? {1'b1, shift_value_ff[6:0]}
                                              : shift_value_ff[7:0];
                  shift_value_in = shift_value_ff >> 7;
                  rsp_last_in    = !value_more;
               end else begin
                  rsp_data_in    = shift_value_ff[7:0];
                  shift_value_in = shift_value_ff >> 8;
                  bytes_left_in  = bytes_left_ff - 1'b1;
                  rsp_last_in    = bytes_left_ff == CountWidth'(1);
               end
               if (rsp_last_in) begin
                  shift_value_in = '0;
                  bytes_left_in  = '0;
                  state_in       = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         shift_tag_ff   <= '0;
         shift_value_ff <= '0;
         bytes_left_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         shift_tag_ff   <= shift_tag_in;
         shift_value_ff <= shift_value_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (bytes_left_ff == '0))
      else $error("byte count left over after a field finished");

   a_fixed_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VALUE && mode_ff != MODE_VARINT) |-> (bytes_left_ff != '0))
      else $error("fixed-width value ran out of bytes before its last byte");

endmodule
